// ===== src/hgba_pkg.sv =====
package hgba_pkg;

   localparam int GROUP_ENTRIES = 1024;
   localparam int HASH_SLOTS    = 2048;

   localparam int GID_W  = $clog2(GROUP_ENTRIES);
   localparam int CNT_W  = $clog2(GROUP_ENTRIES + 1);
   localparam int SLOT_W = $clog2(HASH_SLOTS);

   localparam logic [1:0] CMD_ACCUM = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] CSR_VALUE_WIDTH = 2'd0;
   localparam logic [1:0] CSR_KEY_WIDTH   = 2'd1;

   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   localparam logic [62:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [63:0]  key;
      logic [127:0] sum;
      logic [62:0]  count;
   } grp_entry_type;

   function automatic logic [63:0] extend(input logic [63:0] x, input logic [1:0] sel);
      logic [63:0] r;
      unique case (sel)
         WIDTH_8:  r = {{56{x[7]}}, x[7:0]};
         WIDTH_16: r = {{48{x[15]}}, x[15:0]};
         WIDTH_32: r = {{32{x[31]}}, x[31:0]};
         default:  r = x;
      endcase
      return r;
   endfunction

endpackage

// ===== src/hgba_hash.sv =====
module hgba_hash (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                key,
   output logic                       done,
   output logic [hgba_pkg::SLOT_W-1:0] slot
);
   import hgba_pkg::*;

   localparam int PW = 32 + SLOT_W;
   localparam int HW = (PW + 1) / 2;
   localparam logic [PW-1:0] HASH_MULT = PW'(64'h9E3779B97F4A7C15);

   logic          run_ff, run_in;
   logic [1:0]    step_ff, step_in;
   logic          done_ff, done_in;
   logic [PW-1:0] a_ff, a_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [HW-1:0] op_a, op_b;
   logic [2*HW-1:0] prod;

   always_comb begin
      op_a = a_ff[HW-1:0];
      op_b = HASH_MULT[HW-1:0];
      case (step_ff)
         2'd1: begin
            op_a = HW'(a_ff[PW-1:HW]);
         end
         2'd2: begin
            op_b = HW'(HASH_MULT[PW-1:HW]);
         end
         default: ;
      endcase
   end

   assign prod = op_a * op_b;

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = 2'd0;
         a_in    = key[PW-1:0];
      end else if (run_ff) begin
         if (step_ff == 2'd0) begin
            acc_in = PW'(prod);
         end else begin
            acc_in = acc_ff + PW'({prod, {HW{1'b0}}});
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign slot = acc_ff[PW-1:32];

endmodule

// ===== src/hgba_div.sv =====
module hgba_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [127:0] dividend,
   input  logic [62:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import hgba_pkg::*;

   logic         run_ff, run_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         done_ff, done_in;
   logic         neg_ff, neg_in;
   logic [62:0]  den_ff, den_in;
   logic [62:0]  rem_ff, rem_in;
   logic [127:0] dq_ff, dq_in;
   logic [64:0]  trial;

   assign trial = {1'b0, rem_ff, dq_ff[127]} - {2'b00, den_ff};

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         neg_in = dividend[127];
         den_in = divisor;
         rem_in = '0;
         dq_in  = dividend[127] ? (~dividend + 128'd1) : dividend;
      end else if (run_ff) begin
         if (!trial[64]) begin
            rem_in = trial[62:0];
            dq_in  = {dq_ff[126:0], 1'b1};
         end else begin
            rem_in = {rem_ff[61:0], dq_ff[127]};
            dq_in  = {dq_ff[126:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~dq_ff[63:0] + 64'd1) : dq_ff[63:0];

endmodule

// ===== src/hash_group_by_aggregate_top.sv =====
// channel   ports                             beat taken when
// request   start, busy, req_*                start & !busy
// response  rsp_valid, rsp_*                  rsp_valid (one cycle, no stall)
// csr       csr_valid, csr_ready, csr_*       csr_valid & csr_ready
// accumulate: busy while the key is hashed and its slots are probed in turn; a new key
//    takes the first empty probed slot, a probed slot that holds the key updates its group
// read: busy for a group memory read, the divider steps and a hand-off; a missing group
//    or an unused command answers without raising busy
// clear and reset: a sweep of the slot memory, one slot a cycle
// reset is synchronous; result strobe in the first cycle with busy low, csr writes taken unless in reset
module hash_group_by_aggregate_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_command,
   input  logic [63:0]                 req_row_key,
   input  logic [63:0]                 req_row_value,
   input  logic [hgba_pkg::GID_W-1:0]  req_group_select,
   output logic                        rsp_valid,
   output logic [hgba_pkg::GID_W-1:0]  rsp_group_id,
   output logic                        rsp_table_full,
   output logic                        rsp_entry_valid,
   output logic [63:0]                 rsp_group_key,
   output logic [63:0]                 rsp_sum_high,
   output logic [63:0]                 rsp_sum_low,
   output logic [62:0]                 rsp_row_count,
   output logic [63:0]                 rsp_average,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [1:0]                  csr_data
);
   import hgba_pkg::*;

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_HASH      = 3'd2;
   localparam logic [2:0] S_PROBE_RD  = 3'd3;
   localparam logic [2:0] S_PROBE_CHK = 3'd4;
   localparam logic [2:0] S_GRP_CHK   = 3'd5;
   localparam logic [2:0] S_RD_WAIT   = 3'd6;
   localparam logic [2:0] S_DIV       = 3'd7;

   logic [CNT_W-1:0] slot_mem [HASH_SLOTS];
   grp_entry_type    grp_mem  [GROUP_ENTRIES];

   logic [2:0]        state_ff, state_in;
   logic [1:0]        vws_ff, kws_ff;
   logic [63:0]       key_ff, key_in;
   logic [63:0]       val_ff, val_in;
   logic [GID_W-1:0]  gid_ff, gid_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] probe_ff, probe_in;
   logic [CNT_W-1:0]  groups_ff, groups_in;
   logic              clr_rsp_ff, clr_rsp_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [GID_W-1:0]  rsp_gid_ff, rsp_gid_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_ev_ff, rsp_ev_in;
   logic [63:0]       rsp_key_ff, rsp_key_in;
   logic [63:0]       rsp_sumh_ff, rsp_sumh_in;
   logic [63:0]       rsp_suml_ff, rsp_suml_in;
   logic [62:0]       rsp_cnt_ff, rsp_cnt_in;
   logic [63:0]       rsp_avg_ff, rsp_avg_in;

   logic [CNT_W-1:0]  slot_rd_ff;
   grp_entry_type     grp_rd_ff;
   logic              slot_we;
   logic [CNT_W-1:0]  slot_wdata;
   logic              grp_we;
   logic [GID_W-1:0]  grp_waddr, grp_raddr;
   grp_entry_type     grp_wdata;

   logic              hash_start, hash_done;
   logic [SLOT_W-1:0] hash_slot;
   logic              div_start, div_done;
   logic [63:0]       div_q;

   logic              accept;
   logic [127:0]      new_sum;
   logic [SLOT_W-1:0] slot_next;

   assign accept    = start && !busy;
   assign new_sum   = grp_rd_ff.sum + {{64{val_ff[63]}}, val_ff};
   assign slot_next = (slot_ff == SLOT_W'(HASH_SLOTS - 1)) ? '0 : slot_ff + 1'b1;

   hgba_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_in),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   hgba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (grp_rd_ff.sum),
      .divisor  (grp_rd_ff.count),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      gid_in       = gid_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      groups_in    = groups_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_gid_in   = '0;
      rsp_full_in  = 1'b0;
      rsp_ev_in    = 1'b0;
      rsp_key_in   = '0;
      rsp_sumh_in  = '0;
      rsp_suml_in  = '0;
      rsp_cnt_in   = '0;
      rsp_avg_in   = '0;
      slot_we      = 1'b0;
      slot_wdata   = '0;
      grp_we       = 1'b0;
      grp_waddr    = gid_ff;
      grp_wdata    = grp_rd_ff;
      grp_raddr    = gid_ff;
      hash_start   = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            slot_we = 1'b1;
            slot_in = slot_next;
            if (slot_ff == SLOT_W'(HASH_SLOTS - 1)) begin
               groups_in    = '0;
               state_in     = S_IDLE;
               rsp_valid_in = clr_rsp_ff;
            end
         end
         S_IDLE: begin
            grp_raddr = req_group_select;
            key_in    = extend(req_row_key, kws_ff);
            val_in    = extend(req_row_value, vws_ff);
            gid_in    = req_group_select;
            if (accept) begin
               case (req_command)
                  CMD_ACCUM: begin
                     hash_start = 1'b1;
                     state_in   = S_HASH;
                  end
                  CMD_READ: begin
                     if (CNT_W'(req_group_select) < groups_ff) begin
                        state_in = S_RD_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_gid_in   = req_group_select;
                     end
                  end
                  CMD_CLEAR: begin
                     slot_in    = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_HASH: begin
            if (hash_done) begin
               slot_in  = hash_slot;
               probe_in = '0;
               state_in = S_PROBE_RD;
            end
         end
         S_PROBE_RD: state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (slot_rd_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (groups_ff < CNT_W'(GROUP_ENTRIES)) begin
                  slot_we         = 1'b1;
                  slot_wdata      = groups_ff + 1'b1;
                  grp_we          = 1'b1;
                  grp_waddr       = GID_W'(groups_ff);
                  grp_wdata.key   = key_ff;
                  grp_wdata.sum   = {{64{val_ff[63]}}, val_ff};
                  grp_wdata.count = 63'd1;
                  groups_in       = groups_ff + 1'b1;
                  rsp_gid_in      = GID_W'(groups_ff);
               end else begin
                  rsp_full_in = 1'b1;
               end
            end else begin
               grp_raddr = GID_W'(slot_rd_ff - 1'b1);
               gid_in    = GID_W'(slot_rd_ff - 1'b1);
               state_in  = S_GRP_CHK;
            end
         end
         S_GRP_CHK: begin
            if (grp_rd_ff.key == key_ff) begin
               grp_we          = 1'b1;
               grp_wdata.sum   = new_sum;
               grp_wdata.count = (grp_rd_ff.count != COUNT_MAX) ?
                                 grp_rd_ff.count + 63'd1 : grp_rd_ff.count;
               rsp_valid_in    = 1'b1;
               rsp_gid_in      = gid_ff;
               state_in        = S_IDLE;
            end else if (probe_ff == SLOT_W'(HASH_SLOTS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_full_in  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               slot_in  = slot_next;
               probe_in = probe_ff + 1'b1;
               state_in = S_PROBE_RD;
            end
         end
         S_RD_WAIT: begin
            if (grp_rd_ff.count == '0) begin
               rsp_valid_in = 1'b1;
               rsp_gid_in   = gid_ff;
               rsp_ev_in    = 1'b1;
               rsp_key_in   = grp_rd_ff.key;
               rsp_sumh_in  = grp_rd_ff.sum[127:64];
               rsp_suml_in  = grp_rd_ff.sum[63:0];
               state_in     = S_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_gid_in   = gid_ff;
               rsp_ev_in    = 1'b1;
               rsp_key_in   = grp_rd_ff.key;
               rsp_sumh_in  = grp_rd_ff.sum[127:64];
               rsp_suml_in  = grp_rd_ff.sum[63:0];
               rsp_cnt_in   = grp_rd_ff.count;
               rsp_avg_in   = div_q;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_ff] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[grp_waddr] <= grp_wdata;
      end
      grp_rd_ff <= grp_mem[grp_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         slot_ff      <= '0;
         probe_ff     <= '0;
         groups_ff    <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vws_ff       <= WIDTH_64;
         kws_ff       <= WIDTH_64;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         probe_ff     <= probe_in;
         groups_ff    <= groups_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_VALUE_WIDTH: vws_ff <= csr_data;
               CSR_KEY_WIDTH:   kws_ff <= csr_data;
               default: ;
            endcase
         end
      end
      key_ff      <= key_in;
      val_ff      <= val_in;
      gid_ff      <= gid_in;
      rsp_gid_ff  <= rsp_gid_in;
      rsp_full_ff <= rsp_full_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_sumh_ff <= rsp_sumh_in;
      rsp_suml_ff <= rsp_suml_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_group_id    = rsp_gid_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_entry_valid = rsp_ev_ff;
   assign rsp_group_key   = rsp_key_ff;
   assign rsp_sum_high    = rsp_sumh_ff;
   assign rsp_sum_low     = rsp_suml_ff;
   assign rsp_row_count   = rsp_cnt_ff;
   assign rsp_average     = rsp_avg_ff;

endmodule
